/* sv/rpd_pkg.sv */
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared sizes, codes and types of the response packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

    // Sizing
    localparam int BUFFER_BYTES = 64;
    localparam int TICKS_PER_MS = 3200;
    localparam int BUF_AW       = $clog2(BUFFER_BYTES);
    localparam int IDX_W        = $clog2(BUFFER_BYTES + 1);
    localparam int TMO_W        = 23;
    localparam int CNT_W        = 6;

    // Packet layout
    localparam int HDR_BYTES    = 9;
    localparam int LEN_HI_POS   = 7;
    localparam int LEN_LO_POS   = 8;
    localparam int ACK_POS      = 9;
    localparam int LEN_OVERHEAD = 3;
    localparam int MAX_DATA     = 54;
    localparam int LEN_MAX      = (BUFFER_BYTES - HDR_BYTES < MAX_DATA + LEN_OVERHEAD)
                                  ? (BUFFER_BYTES - HDR_BYTES) : (MAX_DATA + LEN_OVERHEAD);

    // Input item function codes
    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_BYTE  = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_LENERR  = 2'd3;

    typedef logic [BUF_AW-1:0] t_addr;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [TMO_W-1:0]  t_tmo;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Requests from the receive control to the output sequencer
    typedef struct packed {
        logic       single;
        logic [1:0] single_kind;
        logic       burst;
        t_cnt       ndata;
    } t_evt;

    // Status from the output sequencer
    typedef struct packed {
        logic idle;
        logic out_free;
    } t_seq_sts;

endpackage

/* sv/rpd_pkt_ram.sv */
// ----------------------------------------------------------------------------
// rpd_pkt_ram
// Packet byte buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpd_pkt_ram (
    input  logic           i_clk,
    input  logic           i_we,
    input  rpd_pkg::t_addr i_waddr,
    input  logic [7:0]     i_wdata,
    input  logic           i_re,
    input  rpd_pkg::t_addr i_raddr,
    output logic [7:0]     o_rdata
);

    logic [7:0] r_mem [rpd_pkg::BUFFER_BYTES];
    logic [7:0] r_rdata;

    // Write a byte
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read of a byte
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rpd_rx_ctrl.sv */
// ----------------------------------------------------------------------------
// rpd_rx_ctrl
// Receive control: arming, idle timeout, byte indexing, length check and
// completion detection. Writes received bytes into the packet buffer.
// ----------------------------------------------------------------------------
module rpd_rx_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_func,
    input  logic [7:0]        i_rx_byte,
    input  logic [10:0]       i_tmo_ms,
    input  rpd_pkg::t_seq_sts i_sts,
    output rpd_pkg::t_evt     o_evt,
    output logic              o_we,
    output rpd_pkg::t_addr    o_waddr,
    output logic [7:0]        o_wdata
);

    localparam rpd_pkg::t_tmo TPM = rpd_pkg::t_tmo'(rpd_pkg::TICKS_PER_MS);

    logic           r_armed, n_armed;
    rpd_pkg::t_idx  r_index, n_index;
    rpd_pkg::t_tmo  r_idle,  n_idle;
    rpd_pkg::t_tmo  r_limit, n_limit;
    logic           r_hdr,   n_hdr;
    logic           r_hi_nz, n_hi_nz;
    rpd_pkg::t_idx  r_total, n_total;
    rpd_pkg::t_cnt  r_ndata, n_ndata;

    logic           accept;
    rpd_pkg::t_tmo  limit_new;
    logic           len_err;

    // Take a beat only when the sequencer is idle and a result can be held
    assign o_ready  = i_sts.idle & i_sts.out_free;
    assign accept   = i_valid & o_ready;

    assign limit_new = rpd_pkg::t_tmo'({12'd0, i_tmo_ms}) * TPM;
    assign len_err   = r_hi_nz || (i_rx_byte < 8'(rpd_pkg::LEN_OVERHEAD))
                       || (i_rx_byte > 8'(rpd_pkg::LEN_MAX));

    assign o_waddr = r_index[rpd_pkg::BUF_AW-1:0];
    assign o_wdata = i_rx_byte;

    // Next state per accepted beat
    always_comb begin
        n_armed = r_armed;
        n_index = r_index;
        n_idle  = r_idle;
        n_limit = r_limit;
        n_hdr   = r_hdr;
        n_hi_nz = r_hi_nz;
        n_total = r_total;
        n_ndata = r_ndata;
        o_evt   = '0;
        o_we    = 1'b0;
        if (accept) begin
            case (i_func)
                rpd_pkg::FN_START: begin
                    n_index = '0;
                    n_idle  = '0;
                    n_limit = limit_new;
                    n_hdr   = 1'b0;
                    if (limit_new == '0) begin
                        n_armed           = 1'b0;
                        o_evt.single      = 1'b1;
                        o_evt.single_kind = rpd_pkg::KIND_TIMEOUT;
                    end else begin
                        n_armed = 1'b1;
                    end
                end
                rpd_pkg::FN_TICK: begin
                    if (r_armed) begin
                        if (r_idle != '1) begin
                            n_idle = r_idle + 1'b1;
                        end
                        if (n_idle >= r_limit) begin
                            n_armed           = 1'b0;
                            o_evt.single      = 1'b1;
                            o_evt.single_kind = rpd_pkg::KIND_TIMEOUT;
                        end
                    end
                end
                rpd_pkg::FN_BYTE: begin
                    if (r_armed) begin
                        n_idle = '0;
                        if (r_index < rpd_pkg::t_idx'(rpd_pkg::BUFFER_BYTES)) begin
                            o_we    = 1'b1;
                            n_index = r_index + 1'b1;
                        end
                        if (r_index == rpd_pkg::t_idx'(rpd_pkg::LEN_HI_POS)) begin
                            n_hi_nz = (i_rx_byte != 8'd0);
                        end
                        // Check the length on the last header byte
                        if (r_index == rpd_pkg::t_idx'(rpd_pkg::LEN_LO_POS)) begin
                            if (len_err) begin
                                n_armed           = 1'b0;
                                o_evt.single      = 1'b1;
                                o_evt.single_kind = rpd_pkg::KIND_LENERR;
                            end else begin
                                n_hdr   = 1'b1;
                                n_total = rpd_pkg::t_idx'(rpd_pkg::HDR_BYTES)
                                          + rpd_pkg::t_idx'(i_rx_byte);
                                n_ndata = rpd_pkg::t_cnt'(i_rx_byte
                                          - 8'(rpd_pkg::LEN_OVERHEAD));
                            end
                        end
                        // Hand the full packet to the sequencer
                        if (r_hdr && (n_index == r_total)) begin
                            n_armed     = 1'b0;
                            o_evt.burst = 1'b1;
                            o_evt.ndata = r_ndata;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_index <= '0;
            r_idle  <= '0;
            r_limit <= '0;
            r_hdr   <= 1'b0;
        end else begin
            r_armed <= n_armed;
            r_index <= n_index;
            r_idle  <= n_idle;
            r_limit <= n_limit;
            r_hdr   <= n_hdr;
        end
    end

    // Length fields
    always_ff @(posedge i_clk) begin
        r_hi_nz <= n_hi_nz;
        r_total <= n_total;
        r_ndata <= n_ndata;
    end

endmodule

/* sv/rpd_out_seq.sv */
// ----------------------------------------------------------------------------
// rpd_out_seq
// Output sequencer: holds each single result, or the acknowledge code and
// data bytes read out of the packet buffer, in the output register.
// ----------------------------------------------------------------------------
module rpd_out_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpd_pkg::t_evt     i_evt,
    output rpd_pkg::t_seq_sts o_sts,
    output logic              o_re,
    output rpd_pkg::t_addr    o_raddr,
    input  logic [7:0]        i_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_value,
    output rpd_pkg::t_cnt     o_count,
    output logic              o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]     r_state, n_state;
    logic           r_out_valid, n_out_valid;
    rpd_pkg::t_cnt  r_left, n_left;
    rpd_pkg::t_cnt  r_ndata, n_ndata;
    rpd_pkg::t_addr r_addr, n_addr;
    logic           r_first, n_first;
    logic [1:0]     r_kind, n_kind;
    logic [7:0]     r_value, n_value;
    rpd_pkg::t_cnt  r_count, n_count;
    logic           r_last, n_last;
    logic           out_free;

    assign out_free       = !r_out_valid || i_ready;
    assign o_sts.idle     = (r_state == S_IDLE);
    assign o_sts.out_free = out_free;
    assign o_raddr        = r_addr;

    // Sequence results
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        n_left      = r_left;
        n_ndata     = r_ndata;
        n_addr      = r_addr;
        n_first     = r_first;
        n_kind      = r_kind;
        n_value     = r_value;
        n_count     = r_count;
        n_last      = r_last;
        o_re        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_evt.single) begin
                    n_out_valid = 1'b1;
                    n_kind      = i_evt.single_kind;
                    n_value     = 8'd0;
                    n_count     = '0;
                    n_last      = 1'b1;
                end
                if (i_evt.burst) begin
                    n_left  = i_evt.ndata + 1'b1;
                    n_ndata = i_evt.ndata;
                    n_addr  = rpd_pkg::t_addr'(rpd_pkg::ACK_POS);
                    n_first = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // Issue the read once the output register frees up
                if (out_free) begin
                    o_re    = 1'b1;
                    n_addr  = r_addr + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_kind      = r_first ? rpd_pkg::KIND_ACK : rpd_pkg::KIND_DATA;
                n_value     = i_rdata;
                n_count     = r_first ? r_ndata : '0;
                n_last      = (r_left == rpd_pkg::t_cnt'(1));
                n_left      = r_left - 1'b1;
                n_first     = 1'b0;
                n_state     = (r_left == rpd_pkg::t_cnt'(1)) ? S_IDLE : S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_first     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
            r_first     <= n_first;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ndata <= n_ndata;
        r_addr  <= n_addr;
        r_kind  <= n_kind;
        r_value <= n_value;
        r_count <= n_count;
        r_last  <= n_last;
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_count = r_count;
    assign o_last  = r_last;

    // A load never overwrites a result still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_out_valid)
        else $error("output register busy on load");

    // Requests arrive only while idle with room for a result
    a_evt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.single || i_evt.burst) |-> ((r_state == S_IDLE) && out_free))
        else $error("request while sequencer busy");

    // A burst always has results left to read
    a_left_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_left != '0))
        else $error("read with no results left");

    // The first burst result is the acknowledge code
    a_ack_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOAD) && r_first) |=> (r_kind == rpd_pkg::KIND_ACK))
        else $error("burst did not open with acknowledge");

endmodule

/* sv/response_packet_deframer_core.sv */
// ----------------------------------------------------------------------------
// response_packet_deframer_core
// Acknowledge packet deframer with idle timeout and length check.
// ----------------------------------------------------------------------------
// Takes one input beat per cycle while receiving and while the output
// register is free: a start beat arms the block with a timeout of
// tmo_ms * TICKS_PER_MS idle ticks, byte beats are stored in a packet
// buffer and idle ticks count toward the timeout. A timeout or a length
// error result is loaded into the output register at the edge that accepts
// its beat. When the last byte of a packet arrives, the input is held off
// while the acknowledge code and its data bytes stream out: each of these
// ndata + 1 results waits for a free output register, then takes one
// buffer read and one output load. The buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
module response_packet_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] rx_byte, [18:8] tmo_ms, rest zero
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] value, [13:8] data_count, rest zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast
);

    rpd_pkg::t_evt     evt;
    rpd_pkg::t_seq_sts sts;
    logic              we;
    rpd_pkg::t_addr    waddr;
    logic [7:0]        wdata;
    logic              re;
    rpd_pkg::t_addr    raddr;
    logic [7:0]        rdata;
    logic [7:0]        value;
    rpd_pkg::t_cnt     count;

    // Receive control
    rpd_rx_ctrl u_rx_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_func       (i_s_tuser),
        .i_rx_byte    (i_s_tdata[7:0]),
        .i_tmo_ms     (i_s_tdata[18:8]),
        .i_sts        (sts),
        .o_evt        (evt),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata)
    );

    // Packet buffer
    rpd_pkt_ram u_pkt_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Output sequencer
    rpd_out_seq u_out_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_sts   (sts),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (o_m_tuser),
        .o_value (value),
        .o_count (count),
        .o_last  (o_m_tlast)
    );

    // Pack the result beat
    assign o_m_tdata = {2'b00, count, value};

endmodule
